// File: rtl/cbrq_pkg.sv
// Shared types and constants for the counter bank range query block.
// No dependencies.
`timescale 1ns / 1ps
package cbrq_pkg;
    localparam int MAX_COUNTERS = 32;
    localparam int COUNT_WIDTH  = 16;
    localparam int IDX_W        = 6;
    localparam int ADDR_W       = $clog2(MAX_COUNTERS);
    localparam int TALLY_W      = 7;

    typedef logic signed [COUNT_WIDTH-1:0] t_count;

    typedef enum logic [2:0] {
        REQ_INC   = 3'd0,
        REQ_DEC   = 3'd1,
        REQ_RANGE = 3'd2,
        REQ_DUMPI = 3'd3,
        REQ_DUMPC = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        KIND_TALLY = 2'd0,
        KIND_INDEX = 2'd1,
        KIND_COUNT = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]         kind;
        logic [IDX_W-1:0]   index;
        t_count             count;
        logic [TALLY_W-1:0] tally;
        logic               last;
    } t_result;

    // Sort scratch entry: index and count.
    typedef struct packed {
        logic [IDX_W-1:0] index;
        t_count           count;
    } t_entry;
endpackage

// File: rtl/cbrq_mem.sv
// One-port-write, one-port-read synchronous memory with registered read data.
// Generic; used for the counters and the sort scratch.
`timescale 1ns / 1ps
module cbrq_mem #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/counter_bank_range_query_top.sv
// Counter bank range query: top level with request sequencer and two memories.
// Depends on cbrq_pkg and cbrq_mem.
//
// Usage: requests enter on i_valid/o_stall; results leave on o_valid/i_stall.
// Configuration (number of counters in use) is written on i_cfg_valid/o_cfg_ready;
// the user must write it only while the block is idle, as the block does not enforce it.
// Values above 32 act as 32. After reset a clearing pass writes zero to all 32
// counters, one per cycle, while no request is taken.
// One request at a time. Increment/decrement: read, then write back.
// Range count: one counter read per cycle through the counter memory port.
// Index dump: one read per entry, each entry emitted before the next read.
// Count dump: copy the counters to the scratch memory, then for each i a
// read/compare/swap pass over the scratch memory's later entries, then n
// output reads; the sort is paced by the scratch memory's one read port.
// A held result stalls the sequencer; a stalled result holds its payload.
`timescale 1ns / 1ps
module counter_bank_range_query_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_req_type,
    input  logic [5:0]                    i_counter_index,
    input  logic signed [15:0]            i_range_low,
    input  logic signed [15:0]            i_range_high,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [5:0]                    i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_result_kind,
    output logic [5:0]                    o_entry_index,
    output logic signed [15:0]            o_entry_count,
    output logic [6:0]                    o_range_tally,
    output logic                          o_last_of_run
);
    import cbrq_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RMW, S_RMW_WB, S_RANGE, S_DUMPI, S_EMIT,
        S_COPY, S_SI, S_SJ, S_SCMP, S_OUT, S_OUT_EMIT
    } t_state;

    localparam logic [ADDR_W:0] NMAX = (ADDR_W+1)'(MAX_COUNTERS);

    t_state            r_state;
    logic [5:0]        r_ncfg;
    logic [ADDR_W:0]   r_n;
    logic [ADDR_W:0]   r_i, r_j;
    logic [2:0]        r_req;
    logic [ADDR_W-1:0] r_idx;
    t_count            r_lo, r_hi;
    logic [TALLY_W-1:0] r_tally;
    logic              r_rd_pend;
    t_entry            r_ei;
    logic              r_ovalid;
    t_result           r_out;

    // counter memory
    logic              c_we;
    logic [ADDR_W-1:0] c_wa, c_ra;
    t_count            c_wd, c_rd;
    // scratch memory
    logic              s_we;
    logic [ADDR_W-1:0] s_wa, s_ra;
    t_entry            s_wd, s_rd;

    cbrq_mem #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_COUNTERS)) u_cnt (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_wa), .i_wdata(c_wd),
        .i_raddr(c_ra), .o_rdata(c_rd));
    cbrq_mem #(.WIDTH($bits(t_entry)), .DEPTH(MAX_COUNTERS)) u_scr (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd));

    logic out_free;
    logic out_emit;
    assign out_free    = !r_ovalid || !i_stall;
    // a new result is loaded into the output register this cycle
    assign out_emit    = out_free && ((r_state == S_RANGE && r_i == r_n) ||
                                      r_state == S_EMIT || r_state == S_OUT_EMIT);
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid       = r_ovalid;
    assign o_result_kind = r_out.kind;
    assign o_entry_index = r_out.index;
    assign o_entry_count = r_out.count;
    assign o_range_tally = r_out.tally;
    assign o_last_of_run = r_out.last;

    logic [ADDR_W:0] n_eff;
    assign n_eff = ({1'b0, r_ncfg} > 7'(NMAX)) ? NMAX : r_ncfg[ADDR_W:0];

    // Memory port drive is combinational from state.
    always_comb begin
        c_we = 1'b0; c_wa = r_idx; c_wd = c_rd; c_ra = r_i[ADDR_W-1:0];
        s_we = 1'b0; s_wa = r_i[ADDR_W-1:0]; s_wd = r_ei; s_ra = r_i[ADDR_W-1:0];
        unique case (r_state)
            S_CLEAR: begin
                c_we = 1'b1; c_wa = r_i[ADDR_W-1:0]; c_wd = '0;
            end
            S_RMW:   c_ra = r_idx;
            S_RMW_WB: begin
                if (r_req == REQ_INC && c_rd != {1'b0, {(COUNT_WIDTH-1){1'b1}}}) begin
                    c_we = 1'b1; c_wd = c_rd + t_count'(1);
                end else if (r_req == REQ_DEC &&
                             c_rd != {1'b1, {(COUNT_WIDTH-1){1'b0}}}) begin
                    c_we = 1'b1; c_wd = c_rd - t_count'(1);
                end
            end
            S_COPY: begin
                // write entry for the previous read
                s_we = r_rd_pend; s_wa = r_j[ADDR_W-1:0];
                s_wd = '{index: IDX_W'(r_j), count: c_rd};
            end
            S_SJ:  s_ra = r_j[ADDR_W-1:0];
            S_SCMP: begin
                // swap: scratch[j] <= old i entry; i entry held in r_ei
                if (r_ei.count > s_rd.count) begin
                    s_we = 1'b1; s_wa = r_j[ADDR_W-1:0]; s_wd = r_ei;
                end
            end
            S_SI: begin
                // write back settled entry i when leaving it
                s_we = r_rd_pend; s_wa = r_i[ADDR_W-1:0]; s_wd = r_ei;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_i       <= '0;
            r_ncfg    <= 6'd32;
            r_ovalid  <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            if (i_cfg_valid) r_ncfg <= i_cfg_data;
            if (r_ovalid && !i_stall && !out_emit) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == NMAX - 1'b1) r_state <= S_IDLE;
                end
                S_IDLE: if (i_valid) begin
                    r_req   <= i_req_type;
                    r_idx   <= i_counter_index[ADDR_W-1:0];
                    r_lo    <= i_range_low;
                    r_hi    <= i_range_high;
                    r_n     <= n_eff;
                    r_i     <= '0;
                    r_j     <= '0;
                    r_tally <= '0;
                    r_rd_pend <= 1'b0;
                    case (i_req_type)
                        REQ_INC, REQ_DEC:
                            if ({1'b0, i_counter_index} < 7'(n_eff)) r_state <= S_RMW;
                        REQ_RANGE: r_state <= S_RANGE;
                        REQ_DUMPI: if (n_eff != '0) r_state <= S_DUMPI;
                        REQ_DUMPC: if (n_eff != '0) r_state <= S_COPY;
                        default: ;
                    endcase
                end
                S_RMW:    r_state <= S_RMW_WB;
                S_RMW_WB: r_state <= S_IDLE;
                S_RANGE: begin
                    // read r_i issued; tally previous read data
                    if (r_rd_pend && c_rd >= r_lo && c_rd <= r_hi)
                        r_tally <= r_tally + 1'b1;
                    if (r_i == r_n) begin
                        if (out_free) begin
                            r_ovalid <= 1'b1;
                            r_out <= '{kind: KIND_TALLY, index: '0, count: '0,
                                       tally: (r_rd_pend && c_rd >= r_lo && c_rd <= r_hi)
                                              ? r_tally + 1'b1 : r_tally,
                                       last: 1'b1};
                            r_state <= S_IDLE;
                        end
                        r_rd_pend <= 1'b0;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_rd_pend <= 1'b1;
                    end
                end
                S_DUMPI: r_state <= S_EMIT; // read r_i issued
                S_EMIT: if (out_free) begin
                    r_ovalid <= 1'b1;
                    r_out <= '{kind: KIND_INDEX, index: IDX_W'(r_i), count: c_rd,
                               tally: '0, last: (r_i + 1'b1 == r_n)};
                    r_i <= r_i + 1'b1;
                    r_state <= (r_i + 1'b1 == r_n) ? S_IDLE : S_DUMPI;
                end
                S_COPY: begin
                    // read counter r_i, write previous at r_j
                    if (r_rd_pend && r_j + 1'b1 == r_n) begin
                        r_i <= '0; r_rd_pend <= 1'b0;
                        r_j <= '0;
                        // single-counter bank: nothing to sort, go straight to output
                        r_state <= (r_n == (ADDR_W+1)'(1)) ? S_OUT : S_SI;
                    end else begin
                        r_j <= r_i;
                        r_i <= r_i + 1'b1; r_rd_pend <= 1'b1;
                    end
                end
                S_SI: begin
                    // entry i read issued (at s_ra = r_i); load it next
                    if (r_rd_pend) begin
                        // previous i written back this cycle; advance
                        r_rd_pend <= 1'b0;
                        if (r_i + 2'd2 == r_n) begin
                            r_i <= '0; r_state <= S_OUT;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_j <= r_i + 1'b1;
                        r_state <= S_SJ;
                    end
                end
                S_SJ: begin
                    if (r_j == r_i + 1'b1) r_ei <= s_rd;
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if (r_ei.count > s_rd.count) r_ei <= s_rd;
                    if (r_j + 1'b1 == r_n) begin
                        r_rd_pend <= 1'b1; r_state <= S_SI;
                    end else begin
                        r_j <= r_j + 1'b1; r_state <= S_SJ;
                    end
                end
                S_OUT: r_state <= S_OUT_EMIT;
                S_OUT_EMIT: if (out_free) begin
                    r_ovalid <= 1'b1;
                    r_out <= '{kind: KIND_COUNT, index: s_rd.index, count: s_rd.count,
                               tally: '0, last: (r_i + 1'b1 == r_n)};
                    r_i <= r_i + 1'b1;
                    r_state <= (r_i + 1'b1 == r_n) ? S_IDLE : S_OUT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/cbrq_checker.sv
// Port-level checker for counter_bank_range_query_top, bound to the top.
// Depends on cbrq_pkg and the top level's ports only.
`timescale 1ns / 1ps
module cbrq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_result_kind,
    input logic [5:0]  o_entry_index,
    input logic [6:0]  o_range_tally,
    input logic        o_last_of_run
);
    import cbrq_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_entry_index))
        else $error("stalled result changed");
    a_tally_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_TALLY |->
            o_range_tally <= 7'(MAX_COUNTERS) && o_last_of_run)
        else $error("bad tally transaction");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result_kind <= KIND_COUNT)
        else $error("bad result kind");
    a_dump_tally: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind != KIND_TALLY |-> o_range_tally == 7'd0)
        else $error("dump entry with tally");
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("request taken during clearing pass");
endmodule

bind counter_bank_range_query_top cbrq_checker u_cbrq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_result_kind(o_result_kind),
    .o_entry_index(o_entry_index), .o_range_tally(o_range_tally),
    .o_last_of_run(o_last_of_run));
